// ----- rtl/gelu_pkg.sv -----
// GELU (tanh form) package: payload structs, fixed-point gains, queue sizing
// and the output saturation helper. Depends on nothing.
package gelu_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int FRONT_STAGES = 11;
    localparam int QUEUE_DEPTH  = 16;
    localparam int SAT_WIDTH    = 2 * SAMPLE_WIDTH + 34;

    // 0.044715 and sqrt(2/pi), both in Q24
    localparam logic signed [20:0] GAIN_C3 = 21'sd750193;
    localparam logic signed [24:0] GAIN_K1 = 25'sd13386282;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    localparam logic signed [SAT_WIDTH-1:0] SAT_HI =
        {{(SAT_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAT_WIDTH-1:0] SAT_LO =
        {{(SAT_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           last_in;
    } gelu_in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] activation_out;
        logic                           last_out;
    } gelu_out_t;

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [SAT_WIDTH-1:0] v
    );
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            r = v[SAMPLE_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/gelu_tanh_activation_top.sv -----
// GELU tanh-approximation top: front pipeline, 16-entry queue, back pipeline.
// Throughput: one sample per cycle while queue credits remain; the front issues against queue credits.
// Reset clears valid bits, credits and queue pointers; the tanh table is
// constant logic and needs no fill. Depends on gelu_pkg, gelu_front,
// gelu_queue, gelu_back.
module gelu_tanh_activation_top #(
    parameter int FRACTION_BITS = 12,
    parameter int TANH_SEGMENTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  gelu_pkg::gelu_in_t  sample,
    output logic                result_valid,
    input  logic                result_ready,
    output gelu_pkg::gelu_out_t result
);

    localparam int W  = gelu_pkg::SAMPLE_WIDTH;
    localparam int IW = $clog2(TANH_SEGMENTS);
    localparam int EW = W + 3 + IW + FRACTION_BITS + 2;

    logic                         push, pop, q_not_empty;
    logic signed [W-1:0]          f_x, h_x;
    logic                         f_last, f_big, f_neg;
    logic                         h_last, h_big, h_neg;
    logic [IW-1:0]                f_idx, h_idx;
    logic [FRACTION_BITS+1:0]     f_frac, h_frac;
    logic [EW-1:0]                push_data, head;

    gelu_front #(
        .FRACTION_BITS(FRACTION_BITS),
        .TANH_SEGMENTS(TANH_SEGMENTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .pop         (pop),
        .push        (push),
        .x           (f_x),
        .last        (f_last),
        .big         (f_big),
        .neg         (f_neg),
        .idx         (f_idx),
        .frac        (f_frac)
    );

    assign push_data = {f_x, f_last, f_big, f_neg, f_idx, f_frac};

    gelu_queue #(
        .WIDTH(EW),
        .DEPTH(gelu_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (head),
        .not_empty(q_not_empty)
    );

    assign {h_x, h_last, h_big, h_neg, h_idx, h_frac} = head;

    gelu_back #(
        .FRACTION_BITS(FRACTION_BITS),
        .TANH_SEGMENTS(TANH_SEGMENTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .pop         (pop),
        .q_x         (h_x),
        .q_last      (h_last),
        .q_big       (h_big),
        .q_neg       (h_neg),
        .q_idx       (h_idx),
        .q_frac      (h_frac),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule

// ----- rtl/gelu_queue.sv -----
// GELU decoupling queue: small register FIFO between front and back pipelines.
// Standalone; occupancy is bounded by the front credit counter.
module gelu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

endmodule

// ----- rtl/gelu_front.sv -----
// GELU front pipeline: accepts samples, forms x^3, the tanh argument u and
// its table segment and fraction. Depends on gelu_pkg.
module gelu_front #(
    parameter int FRACTION_BITS = 12,
    parameter int TANH_SEGMENTS = 64
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  gelu_pkg::gelu_in_t                        sample,
    input  logic                                      sample_valid,
    output logic                                      sample_ready,
    input  logic                                      pop,
    output logic                                      push,
    output logic signed [gelu_pkg::SAMPLE_WIDTH-1:0]  x,
    output logic                                      last,
    output logic                                      big,
    output logic                                      neg,
    output logic [$clog2(TANH_SEGMENTS)-1:0]          idx,
    output logic [FRACTION_BITS+1:0]                  frac
);

    localparam int W   = gelu_pkg::SAMPLE_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int NS  = gelu_pkg::FRONT_STAGES;
    localparam int IW  = $clog2(TANH_SEGMENTS);
    localparam int CW  = (W + 1 > F + 3) ? W + 1 : F + 3;
    localparam int PW  = F + 2 + IW;
    localparam int CRW = $clog2(gelu_pkg::QUEUE_DEPTH + 1);

    localparam logic signed [2*W:0]  HALF_F   = (2*W+1)'(1) << (F - 1);
    localparam logic signed [W+21:0] HALF_C3  = (W+22)'(1) << 23;
    localparam logic signed [W+26:0] HALF_K1  = (W+27)'(1) << 23;
    localparam logic [CW-1:0]        LIMIT    = CW'(4) << F;
    localparam logic [PW-1:0]        SEGS_C   = PW'(TANH_SEGMENTS);

    logic                     accept;
    logic [CRW-1:0]           credit_reg, credit_next;
    logic [NS-1:0]            valid_reg, valid_next;

    logic signed [W-1:0]      x_reg [NS];
    logic                     last_reg [NS];

    logic signed [2*W-1:0]    xx_reg, xx_next;
    logic signed [2*W:0]      xx_sum, xx_rnd;
    logic signed [W-1:0]      x2_reg, x2_next;
    logic signed [2*W-1:0]    m3_reg, m3_next;
    logic signed [2*W:0]      m3_sum, m3_rnd;
    logic signed [W-1:0]      x3_reg, x3_next;
    logic signed [W+20:0]     c3_reg, c3_next;
    logic signed [W+21:0]     c3_sum, c3_rnd, s_sum;
    logic signed [W:0]        s_reg, s_next;
    logic signed [W+25:0]     k_reg, k_next;
    logic signed [W+26:0]     k_sum, k_rnd;
    logic signed [W:0]        u_reg, u_next;
    logic [W:0]               a_mag;
    logic [CW-1:0]            a_ext;
    logic [F+1:0]             a_low_reg, a_low_next;
    logic                     big_a_reg, big_a_next;
    logic                     neg_a_reg, neg_a_next;
    logic [PW-1:0]            p_full;
    logic [IW-1:0]            idx_reg, idx_next;
    logic [F+1:0]             frac_reg, frac_next;
    logic                     big_reg, neg_reg;

    assign sample_ready = (credit_reg < CRW'(gelu_pkg::QUEUE_DEPTH));
    assign accept       = sample_valid && sample_ready;
    assign valid_next   = {valid_reg[NS-2:0], accept};

    always_comb
    begin
        case ({accept, pop})
            2'b10:   credit_next = credit_reg + CRW'(1);
            2'b01:   credit_next = credit_reg - CRW'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_comb
    begin
        xx_next = x_reg[0] * x_reg[0];
        xx_sum  = (2*W+1)'(xx_reg) + HALF_F;
        xx_rnd  = xx_sum >>> F;
        x2_next = gelu_pkg::sat_sample(gelu_pkg::SAT_WIDTH'(xx_rnd));

        m3_next = x2_reg * x_reg[2];
        m3_sum  = (2*W+1)'(m3_reg) + HALF_F;
        m3_rnd  = m3_sum >>> F;
        x3_next = gelu_pkg::sat_sample(gelu_pkg::SAT_WIDTH'(m3_rnd));

        c3_next = x3_reg * gelu_pkg::GAIN_C3;
        c3_sum  = (W+22)'(c3_reg) + HALF_C3;
        c3_rnd  = c3_sum >>> 24;
        s_sum   = (W+22)'(x_reg[5]) + c3_rnd;
        s_next  = s_sum[W:0];

        k_next  = s_reg * gelu_pkg::GAIN_K1;
        k_sum   = (W+27)'(k_reg) + HALF_K1;
        k_rnd   = k_sum >>> 24;
        u_next  = k_rnd[W:0];

        a_mag      = u_reg[W] ? (W+1)'(-u_reg) : (W+1)'(u_reg);
        a_ext      = CW'(a_mag);
        big_a_next = (a_ext >= LIMIT);
        neg_a_next = u_reg[W];
        a_low_next = a_ext[F+1:0];

        p_full    = PW'(a_low_reg) * SEGS_C;
        idx_next  = p_full[PW-1:F+2];
        frac_next = p_full[F+1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            valid_reg  <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= sample.sample_in;
        last_reg[0] <= sample.last_in;
        for (int k = 1; k < NS; k++)
        begin
            x_reg[k]    <= x_reg[k-1];
            last_reg[k] <= last_reg[k-1];
        end
        xx_reg    <= xx_next;
        x2_reg    <= x2_next;
        m3_reg    <= m3_next;
        x3_reg    <= x3_next;
        c3_reg    <= c3_next;
        s_reg     <= s_next;
        k_reg     <= k_next;
        u_reg     <= u_next;
        a_low_reg <= a_low_next;
        big_a_reg <= big_a_next;
        neg_a_reg <= neg_a_next;
        idx_reg   <= idx_next;
        frac_reg  <= frac_next;
        big_reg   <= big_a_reg;
        neg_reg   <= neg_a_reg;
    end

    assign push = valid_reg[NS-1];
    assign x    = x_reg[NS-1];
    assign last = last_reg[NS-1];
    assign big  = big_reg;
    assign neg  = neg_reg;
    assign idx  = idx_reg;
    assign frac = frac_reg;

endmodule

// ----- rtl/gelu_back.sv -----
// GELU back pipeline: tanh table interpolation, 0.5*x*(1+tanh) and output
// register with stall. Depends on gelu_pkg.
module gelu_back #(
    parameter int FRACTION_BITS = 12,
    parameter int TANH_SEGMENTS = 64
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      q_not_empty,
    output logic                                      pop,
    input  logic signed [gelu_pkg::SAMPLE_WIDTH-1:0]  q_x,
    input  logic                                      q_last,
    input  logic                                      q_big,
    input  logic                                      q_neg,
    input  logic [$clog2(TANH_SEGMENTS)-1:0]          q_idx,
    input  logic [FRACTION_BITS+1:0]                  q_frac,
    output logic                                      result_valid,
    input  logic                                      result_ready,
    output gelu_pkg::gelu_out_t                       result
);

    localparam int W   = gelu_pkg::SAMPLE_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int TW  = $clog2(TANH_SEGMENTS + 1);
    localparam int DPW = 32 + F + 3;

    localparam logic signed [W+33:0] HALF_Y = (W+34)'(1) << 30;

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [30:0] tanh_entry(input int i);
        longint a;
        longint a2;
        longint a3;
        longint a5;
        longint a7;
        longint t;
        longint den;
        longint one;
        one = longint'(1) <<< 30;
        a   = (longint'(i) <<< 26) / TANH_SEGMENTS;
        a2  = (a * a) >>> 30;
        a3  = (a2 * a) >>> 30;
        a5  = (a3 * a2) >>> 30;
        a7  = (a5 * a2) >>> 30;
        t   = a - a3 / 3 + (2 * a5) / 15 - (17 * a7) / 315;
        if (t < 0)
        begin
            t = 0;
        end
        for (int k = 0; k < 6; k++)
        begin
            den = one + ((t * t) >>> 30);
            t   = longint'(udiv64(64'(t) << 31, 64'(den)));
        end
        if (t > one)
        begin
            t = one;
        end
        return t[30:0];
    endfunction

    logic [30:0] tbl [TANH_SEGMENTS+1];

    for (genvar g = 0; g <= TANH_SEGMENTS; g++)
    begin : g_tbl
        assign tbl[g] = tanh_entry(g);
    end

    logic                   en;
    logic [3:0]             vb_reg;
    logic                   out_valid_reg;
    gelu_pkg::gelu_out_t    result_reg;

    logic [TW-1:0]          idx_lo, idx_hi;
    logic [30:0]            t0_next;
    logic signed [31:0]     diff_next;

    logic [30:0]            t0_reg, t0b_reg;
    logic signed [31:0]     diff_reg;
    logic [F+1:0]           frac_reg;
    logic                   big0_reg, big1_reg;
    logic                   neg0_reg, neg1_reg;
    logic signed [W-1:0]    x0_reg, x1_reg, x2_reg;
    logic                   last0_reg, last1_reg, last2_reg, last3_reg;
    logic signed [DPW-1:0]  dprod_reg, dprod_next, interp_full;
    logic signed [31:0]     interp, mag, th;
    logic signed [32:0]     g_reg, g_next;
    logic signed [W+32:0]   yp_reg, yp_next;
    logic signed [W+33:0]   y_sum, y_rnd;

    assign en  = !out_valid_reg || result_ready;
    assign pop = en && q_not_empty;

    always_comb
    begin
        idx_lo    = TW'(q_idx);
        idx_hi    = idx_lo + TW'(1);
        t0_next   = tbl[idx_lo];
        diff_next = $signed({1'b0, tbl[idx_hi]}) - $signed({1'b0, t0_next});

        dprod_next  = diff_reg * $signed({1'b0, frac_reg});

        interp_full = dprod_reg >>> (F + 2);
        interp      = interp_full[31:0];
        mag         = big1_reg ? gelu_pkg::ONE_Q30 : $signed({1'b0, t0b_reg}) + interp;
        th          = neg1_reg ? -mag : mag;
        g_next      = 33'(gelu_pkg::ONE_Q30) + 33'(th);

        yp_next = x2_reg * g_reg;
        y_sum   = (W+34)'(yp_reg) + HALF_Y;
        y_rnd   = y_sum >>> 31;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg        <= {vb_reg[2:0], pop};
            out_valid_reg <= vb_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg    <= t0_next;
            diff_reg  <= diff_next;
            frac_reg  <= q_frac;
            big0_reg  <= q_big;
            neg0_reg  <= q_neg;
            x0_reg    <= q_x;
            last0_reg <= q_last;

            dprod_reg <= dprod_next;
            t0b_reg   <= t0_reg;
            big1_reg  <= big0_reg;
            neg1_reg  <= neg0_reg;
            x1_reg    <= x0_reg;
            last1_reg <= last0_reg;

            g_reg     <= g_next;
            x2_reg    <= x1_reg;
            last2_reg <= last1_reg;

            yp_reg    <= yp_next;
            last3_reg <= last2_reg;

            result_reg.activation_out <= gelu_pkg::sat_sample(gelu_pkg::SAT_WIDTH'(y_rnd));
            result_reg.last_out       <= last3_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

// ----- sim/gelu_tanh_activation_top_test.sv -----
// Self-checking bench for gelu_tanh_activation_top: a queue-fed driver, a random-stall
// receiver and a bit-exact GELU (tanh form) predictor checked on every result transfer.
// Depends on gelu_pkg and gelu_tanh_activation_top.
module gelu_tanh_activation_top_test;

    localparam int FRAC_BITS  = 12;
    localparam int SEGMENTS   = 64;
    localparam int RAND_ITEMS = 1400;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_AT   = 700;
    localparam int TAIL       = 40;
    localparam longint ONE    = 64'sd1 <<< 30;

    typedef struct {
        gelu_pkg::gelu_in_t item;
        int                 gap;
        bit                 drain;
    } pending_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_ready;
    gelu_pkg::gelu_in_t  sample = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    gelu_pkg::gelu_out_t result;

    pending_t            pending_q[$];
    gelu_pkg::gelu_out_t gelu_expected_q[$];
    longint              tanh_knots[0:SEGMENTS];

    int accepted_count = 0;
    int offered_count  = 0;
    int result_count   = 0;
    int error_count    = 0;
    int directed_count = 0;
    bit stim_done      = 1'b0;
    bit hold_on        = 1'b0;

    gelu_tanh_activation_top #(
        .FRACTION_BITS(FRAC_BITS),
        .TANH_SEGMENTS(SEGMENTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample(sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic longint round_shr(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip_sample(longint v);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (gelu_pkg::SAMPLE_WIDTH - 1)) - 1;
        lo = -(64'sd1 <<< (gelu_pkg::SAMPLE_WIDTH - 1));
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    task automatic build_tanh_knots();
        longint a;
        longint a2;
        longint a3;
        longint a5;
        longint a7;
        longint t;
        longint den;
        for (int i = 0; i <= SEGMENTS; i++)
        begin
            a  = (longint'(i) <<< 26) / SEGMENTS;
            a2 = (a * a) >>> 30;
            a3 = (a2 * a) >>> 30;
            a5 = (a3 * a2) >>> 30;
            a7 = (a5 * a2) >>> 30;
            t  = a - a3 / 3 + (2 * a5) / 15 - (17 * a7) / 315;
            if (t < 0)
            begin
                t = 0;
            end
            for (int k = 0; k < 6; k++)
            begin
                den = ONE + ((t * t) >>> 30);
                t   = (t <<< 31) / den;
            end
            if (t > ONE)
            begin
                t = ONE;
            end
            tanh_knots[i] = t;
        end
    endtask

    function automatic gelu_pkg::gelu_out_t gelu_of(gelu_pkg::gelu_in_t item);
        longint x;
        longint x2;
        longint x3;
        longint s;
        longint u;
        longint a;
        longint p;
        longint f;
        longint th;
        longint y;
        int idx;
        gelu_pkg::gelu_out_t r;
        x  = longint'($signed(item.sample_in));
        x2 = clip_sample(round_shr(x * x, FRAC_BITS));
        x3 = clip_sample(round_shr(x2 * x, FRAC_BITS));
        s  = x + round_shr(x3 * longint'(gelu_pkg::GAIN_C3), 24);
        u  = round_shr(s * longint'(gelu_pkg::GAIN_K1), 24);
        a  = (u < 0) ? -u : u;
        if (a >= (64'sd4 <<< FRAC_BITS))
        begin
            th = ONE;
        end
        else
        begin
            p   = a * SEGMENTS;
            idx = int'(p >>> (FRAC_BITS + 2));
            f   = p & ((64'sd1 <<< (FRAC_BITS + 2)) - 1);
            if (idx > SEGMENTS - 1)
            begin
                idx = SEGMENTS - 1;
            end
            th = tanh_knots[idx] +
                 (((tanh_knots[idx + 1] - tanh_knots[idx]) * f) >>> (FRAC_BITS + 2));
        end
        if (u < 0)
        begin
            th = -th;
        end
        y = clip_sample(round_shr(x * (ONE + th), 31));
        r.activation_out = y[gelu_pkg::SAMPLE_WIDTH-1:0];
        r.last_out       = item.last_in;
        return r;
    endfunction

    task automatic queue_sample(int v, bit last, int gap, bit drain);
        pending_t p;
        p.item.sample_in = v[gelu_pkg::SAMPLE_WIDTH-1:0];
        p.item.last_in   = last;
        p.gap            = gap;
        p.drain          = drain;
        pending_q.push_back(p);
    endtask

    function automatic int draw_sample();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            v = $urandom;
        end
        else if (pick < 70)
        begin
            v = $urandom_range(0, 24000) - 12000;
        end
        else if (pick < 85)
        begin
            v = $urandom_range(13300, 14100);
            if ($urandom_range(0, 1))
            begin
                v = -v;
            end
        end
        else if (pick < 95)
        begin
            v = $urandom_range(11000, 12200);
            if ($urandom_range(0, 1))
            begin
                v = -v;
            end
        end
        else
        begin
            v = $urandom_range(0, 1) ? $urandom_range(32700, 32767)
                                     : -$urandom_range(32700, 32768);
        end
        return v;
    endfunction

    initial
    begin
        int directed[$];
        int vec_left;
        int gap;
        bit last;
        directed = '{0, 1, -1, 32767, -32768, 4096, -4096, 8192, -8192, 11585, 11586,
                     -11585, -11586, 13680, -13680, 13700, -13700, 16384, -16384,
                     32766, -32767, 2, -2, 24000, -24000};
        build_tanh_knots();
        foreach (directed[i])
        begin
            queue_sample(directed[i], i[0], (i % 4 == 0) ? 3 : 0, 1'b0);
        end
        directed_count = directed.size();
        vec_left = 0;
        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            if (vec_left == 0)
            begin
                vec_left = $urandom_range(1, 32);
            end
            vec_left--;
            last = (vec_left == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                last = $urandom_range(0, 1);
            end
            gap = ((k / 150) % 3 == 0) ? 0 : $urandom_range(0, 16);
            queue_sample(draw_sample(), last, gap, k == DRAIN_AT);
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Driver: one pending item at a time, gap before each offer.
    pending_t next_item;
    bit       have_next = 1'b0;
    int       gap_left  = 0;

    always @(negedge clk)
    begin
        if (rst_n && !(sample_valid && accepted_count != offered_count))
        begin
            if (!have_next && pending_q.size() != 0)
            begin
                next_item = pending_q.pop_front();
                have_next = 1'b1;
                gap_left  = hold_on ? 0 : next_item.gap;
            end
            if (!have_next)
            begin
                sample_valid <= 1'b0;
                stim_done = 1'b1;
            end
            else if (gap_left > 0 && !hold_on)
            begin
                gap_left--;
                sample_valid <= 1'b0;
            end
            else if (next_item.drain && gelu_expected_q.size() != 0)
            begin
                sample_valid <= 1'b0;
            end
            else
            begin
                sample       <= next_item.item;
                sample_valid <= 1'b1;
                offered_count++;
                have_next = 1'b0;
            end
        end
    end

    // Receiver: random stall after each transfer outside the no-stall windows, one long hold-off.
    int  seen_count = 0;
    int  rx_wait    = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
                if (hold_left == 0)
                begin
                    hold_on <= 1'b0;
                end
            end
            else if (seen_count != result_count)
            begin
                seen_count = result_count;
                if (seen_count >= HOLD_AT && !hold_done)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_LEN;
                    hold_on      <= 1'b1;
                    result_ready <= 1'b0;
                end
                else
                begin
                    rx_wait = ((seen_count / 120) % 3 == 1) ? 0 : $urandom_range(0, 16);
                    result_ready <= (rx_wait == 0);
                end
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                result_ready <= (rx_wait == 0);
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // Predict on input transfer, check on result transfer.
    always @(posedge clk)
    begin
        gelu_pkg::gelu_out_t want;
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
            begin
                gelu_expected_q.push_back(gelu_of(sample));
                accepted_count++;
            end
            if (result_valid && result_ready)
            begin
                result_count++;
                if (gelu_expected_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result activation_out=%0d last_out=%0b",
                             $time, $signed(result.activation_out), result.last_out);
                end
                else
                begin
                    want = gelu_expected_q.pop_front();
                    if (result.activation_out !== want.activation_out)
                    begin
                        error_count++;
                        $display("%0t: activation_out expected %0d actual %0d", $time,
                                 $signed(want.activation_out),
                                 $signed(result.activation_out));
                    end
                    if (result.last_out !== want.last_out)
                    begin
                        error_count++;
                        $display("%0t: last_out expected %0b actual %0b", $time,
                                 want.last_out, result.last_out);
                    end
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (gelu_expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL) @(posedge clk);
        $display("Sent %0d samples (%0d directed), checked %0d results, %0d mismatches.",
                 accepted_count, directed_count, result_count, error_count);
        $display("Run included a %0d-cycle receiver hold-off and one full drain pause.",
                 HOLD_LEN);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
